// File: sv/sphere_window_threshold_density_unit_macros.svh
// ----------------------------------------------------------------------------
// Sphere window density: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERE_WINDOW_THRESHOLD_DENSITY_UNIT_MACROS_SVH
`define SPHERE_WINDOW_THRESHOLD_DENSITY_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SWTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/swtd_pkg.sv
// ----------------------------------------------------------------------------
// Sphere window density: package
// Item types, configuration bundle, register indexes and shared constants.
// ----------------------------------------------------------------------------
package swtd_pkg;

    localparam int MAX_EXTENT_DEF = 32;
    localparam int MAX_RADIUS_DEF = 15;

    localparam int POS_W      = 5;
    localparam int VOXEL_W    = 16;
    localparam int COUNT_W    = 15;
    localparam int EXT_W      = 6;
    localparam int RAD_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // present when above * PRESENT_RATIO > inside (above exceeds one fifth)
    localparam int PRESENT_RATIO = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

    localparam logic [EXT_W-1:0]   EXTENT_RST    = 6'd32;
    localparam logic [RAD_W-1:0]   RADIUS_RST    = 4'd4;
    localparam logic [VOXEL_W-1:0] THRESHOLD_RST = 16'd13107;

    typedef struct packed {
        logic               operation;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [VOXEL_W-1:0] voxel_value;
    } in_item_t;

    typedef struct packed {
        logic               present;
        logic [COUNT_W-1:0] inside_count;
        logic [COUNT_W-1:0] above_count;
    } out_item_t;

    typedef struct packed {
        logic [EXT_W-1:0]   extent_x;
        logic [EXT_W-1:0]   extent_y;
        logic [EXT_W-1:0]   extent_z;
        logic [RAD_W-1:0]   window_radius;
        logic [VOXEL_W-1:0] level_threshold;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

// File: sv/swtd_voxel_mem.sv
// ----------------------------------------------------------------------------
// Sphere window density: voxel store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module swtd_voxel_mem #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = swtd_pkg::VOXEL_W
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] store_mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/swtd_scan.sv
// ----------------------------------------------------------------------------
// Sphere window density: window scanner
// Walks the (2r+1)^3 cube one position a cycle, reads in-sphere voxels from
// the store and counts inside and above-threshold voxels.
// ----------------------------------------------------------------------------
module swtd_scan #(
    parameter int MAX_EXTENT = swtd_pkg::MAX_EXTENT_DEF,
    parameter int MAX_RADIUS = swtd_pkg::MAX_RADIUS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swtd_pkg::cfg_t                      cfg,
    input  logic                                launch,
    input  logic [swtd_pkg::POS_W-1:0]          center_x,
    input  logic [swtd_pkg::POS_W-1:0]          center_y,
    input  logic [swtd_pkg::POS_W-1:0]          center_z,
    output logic                                busy,
    output logic                                rd_en,
    output logic [3*$clog2(MAX_EXTENT)-1:0]     rd_addr,
    input  logic [swtd_pkg::VOXEL_W-1:0]        rd_data,
    output logic                                done,
    output swtd_pkg::out_item_t                 result
);

    localparam int AW    = $clog2(MAX_EXTENT);
    localparam int EW    = $clog2(MAX_EXTENT + 1);
    localparam int MW    = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W = MW + 1;
    localparam int CW    = swtd_pkg::POS_W + 1;
    localparam int SUM_W = ((OFS_W > CW) ? OFS_W : CW) + 1;
    localparam int XW    = (SUM_W > EW + 1) ? SUM_W : EW + 1;
    localparam int LW    = (EW > swtd_pkg::EXT_W) ? EW : swtd_pkg::EXT_W;
    localparam int RW    = (MW > swtd_pkg::RAD_W) ? MW : swtd_pkg::RAD_W;
    localparam int R2_W  = 2 * MW;
    localparam int SQ_W  = 2 * MW + 2;
    localparam int CNT_W = $clog2((2 * MAX_RADIUS + 1) ** 3 + 1);
    localparam int PR_W  = CNT_W + 3;

    localparam logic signed [OFS_W-1:0] ONE_S = 1;

    swtd_pkg::state_t state_reg, state_next;

    logic [swtd_pkg::POS_W-1:0] cx_reg, cx_next;
    logic [swtd_pkg::POS_W-1:0] cy_reg, cy_next;
    logic [swtd_pkg::POS_W-1:0] cz_reg, cz_next;
    logic [MW-1:0]              r_reg, r_next;
    logic [R2_W-1:0]            r2_reg, r2_next;
    logic signed [OFS_W-1:0]    dx_reg, dx_next;
    logic signed [OFS_W-1:0]    dy_reg, dy_next;
    logic signed [OFS_W-1:0]    dz_reg, dz_next;
    logic                       hit_reg, hit_next;
    logic [CNT_W-1:0]           inside_reg, inside_next;
    logic [CNT_W-1:0]           above_reg, above_next;
    logic                       done_reg, done_next;
    swtd_pkg::out_item_t        result_reg, result_next;

    logic [RW-1:0]           radius_ext;
    logic [MW-1:0]           r_eff;
    logic signed [OFS_W-1:0] pos_r;
    logic signed [OFS_W-1:0] neg_r;
    logic [EW-1:0]           ex_x, ex_y, ex_z;
    logic signed [XW-1:0]    crd_x, crd_y, crd_z;
    logic                    in_range;
    logic [SQ_W-1:0]         dist2;
    logic                    hit_now;
    logic                    last_pos;
    logic [CNT_W-1:0]        inside_acc;
    logic [CNT_W-1:0]        above_acc;

    function automatic logic [EW-1:0] clamp_ext(input logic [swtd_pkg::EXT_W-1:0] e);
        logic [LW-1:0] e_l;
        e_l = LW'(e);
        return (e_l > LW'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(e_l);
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [OFS_W-1:0] d);
        logic signed [OFS_W-1:0] n;
        n = -d;
        return d[OFS_W-1] ? MW'(n) : MW'(d);
    endfunction

    function automatic logic in_axis(input logic signed [XW-1:0] c, input logic [EW-1:0] e);
        return !c[XW-1] && ($unsigned(c) < XW'(e));
    endfunction

    // ---- datapath helpers ----
    always_comb
    begin
        radius_ext = RW'(cfg.window_radius);
        r_eff      = (radius_ext > RW'(MAX_RADIUS)) ? MW'(MAX_RADIUS) : MW'(radius_ext);
        pos_r      = $signed({1'b0, r_reg});
        neg_r      = -pos_r;

        ex_x = clamp_ext(cfg.extent_x);
        ex_y = clamp_ext(cfg.extent_y);
        ex_z = clamp_ext(cfg.extent_z);

        crd_x = XW'($signed({1'b0, cx_reg})) + XW'(dx_reg);
        crd_y = XW'($signed({1'b0, cy_reg})) + XW'(dy_reg);
        crd_z = XW'($signed({1'b0, cz_reg})) + XW'(dz_reg);

        in_range = in_axis(crd_x, ex_x) && in_axis(crd_y, ex_y) && in_axis(crd_z, ex_z);

        dist2 = SQ_W'(mag(dx_reg)) * SQ_W'(mag(dx_reg))
              + SQ_W'(mag(dy_reg)) * SQ_W'(mag(dy_reg))
              + SQ_W'(mag(dz_reg)) * SQ_W'(mag(dz_reg));

        hit_now  = in_range && (dist2 <= SQ_W'(r2_reg));
        last_pos = (dx_reg == pos_r) && (dy_reg == pos_r) && (dz_reg == pos_r);

        // read data lands in the cycle after the request, tagged by hit_reg
        inside_acc = inside_reg + CNT_W'(hit_reg);
        above_acc  = above_reg + CNT_W'(hit_reg && (rd_data > cfg.level_threshold));
    end

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swtd_pkg::ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = swtd_pkg::ST_SCAN;
                end
            end
            swtd_pkg::ST_SCAN:
            begin
                if (last_pos)
                begin
                    state_next = swtd_pkg::ST_FLUSH;
                end
            end
            swtd_pkg::ST_FLUSH:
            begin
                state_next = swtd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = swtd_pkg::ST_IDLE;
            end
        endcase
    end

    // ---- outputs ----
    always_comb
    begin
        busy  = (state_reg != swtd_pkg::ST_IDLE);
        rd_en = (state_reg == swtd_pkg::ST_SCAN) && hit_now;
    end

    assign rd_addr = {AW'(crd_x), AW'(crd_y), AW'(crd_z)};
    assign done    = done_reg;
    assign result  = result_reg;

    // ---- counters and accumulators ----
    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        r_next      = r_reg;
        r2_next     = r2_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dz_next     = dz_reg;
        hit_next    = 1'b0;
        inside_next = inside_reg;
        above_next  = above_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            swtd_pkg::ST_IDLE:
            begin
                if (launch)
                begin
                    cx_next     = center_x;
                    cy_next     = center_y;
                    cz_next     = center_z;
                    r_next      = r_eff;
                    r2_next     = R2_W'(r_eff) * R2_W'(r_eff);
                    dx_next     = -$signed({1'b0, r_eff});
                    dy_next     = -$signed({1'b0, r_eff});
                    dz_next     = -$signed({1'b0, r_eff});
                    inside_next = '0;
                    above_next  = '0;
                end
            end
            swtd_pkg::ST_SCAN:
            begin
                inside_next = inside_acc;
                above_next  = above_acc;
                hit_next    = hit_now;
                // z runs fastest, then y, then x
                if (dz_reg == pos_r)
                begin
                    dz_next = neg_r;
                    if (dy_reg == pos_r)
                    begin
                        dy_next = neg_r;
                        dx_next = dx_reg + ONE_S;
                    end
                    else
                    begin
                        dy_next = dy_reg + ONE_S;
                    end
                end
                else
                begin
                    dz_next = dz_reg + ONE_S;
                end
            end
            swtd_pkg::ST_FLUSH:
            begin
                inside_next              = inside_acc;
                above_next               = above_acc;
                done_next                = 1'b1;
                result_next.present      = (PR_W'(above_acc) * PR_W'(swtd_pkg::PRESENT_RATIO))
                                           > PR_W'(inside_acc);
                result_next.inside_count = swtd_pkg::COUNT_W'(inside_acc);
                result_next.above_count  = swtd_pkg::COUNT_W'(above_acc);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swtd_pkg::ST_IDLE;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        r_reg      <= r_next;
        r2_reg     <= r2_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        inside_reg <= inside_next;
        above_reg  <= above_next;
        result_reg <= result_next;
    end

endmodule

// File: sv/sphere_window_threshold_density_unit.sv
// ----------------------------------------------------------------------------
// Sphere window threshold density unit
// Voxel store with a sphere-window threshold count on query.
// ----------------------------------------------------------------------------
// A write item leaves busy low; a new item may follow at once. A query item
// holds busy high while the scanner visits each position of the (2r+1)^3
// window (r the clamped radius) one position per cycle through the single
// read port of the voxel store, then a flush state lets the last read return.
// The result is shown with done for one cycle right after busy falls and
// cannot be held off, so the receiver must take it then. The store has no
// reset; every voxel a query touches must have been written first.
module sphere_window_threshold_density_unit #(
    parameter int MAX_EXTENT = swtd_pkg::MAX_EXTENT_DEF,
    parameter int MAX_RADIUS = swtd_pkg::MAX_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  swtd_pkg::in_item_t                item,
    output logic                              done,
    output swtd_pkg::out_item_t               result,
    input  logic                              cfg_we,
    input  logic [swtd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [swtd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int AW     = $clog2(MAX_EXTENT);
    localparam int ADDR_W = 3 * AW;
    localparam int EW     = $clog2(MAX_EXTENT + 1);
    localparam int PW     = (EW > swtd_pkg::POS_W) ? EW : swtd_pkg::POS_W;

    swtd_pkg::cfg_t cfg_reg, cfg_next;

    logic              accept;
    logic              launch;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [swtd_pkg::VOXEL_W-1:0] rd_data;

    // ---- configuration registers ----
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                swtd_pkg::REG_EXTENT_X:  cfg_next.extent_x = cfg_wdata[swtd_pkg::EXT_W-1:0];
                swtd_pkg::REG_EXTENT_Y:  cfg_next.extent_y = cfg_wdata[swtd_pkg::EXT_W-1:0];
                swtd_pkg::REG_EXTENT_Z:  cfg_next.extent_z = cfg_wdata[swtd_pkg::EXT_W-1:0];
                swtd_pkg::REG_RADIUS:
                    cfg_next.window_radius = cfg_wdata[swtd_pkg::RAD_W-1:0];
                swtd_pkg::REG_THRESHOLD:
                    cfg_next.level_threshold = cfg_wdata[swtd_pkg::VOXEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.extent_x        <= swtd_pkg::EXTENT_RST;
            cfg_reg.extent_y        <= swtd_pkg::EXTENT_RST;
            cfg_reg.extent_z        <= swtd_pkg::EXTENT_RST;
            cfg_reg.window_radius   <= swtd_pkg::RADIUS_RST;
            cfg_reg.level_threshold <= swtd_pkg::THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- item decode ----
    assign accept = start && !busy;
    assign launch = accept && (item.operation == swtd_pkg::OP_QUERY);

    // writes beyond the store are dropped
    assign wr_en = accept && (item.operation == swtd_pkg::OP_WRITE)
                && (PW'(item.pos_x) < PW'(MAX_EXTENT))
                && (PW'(item.pos_y) < PW'(MAX_EXTENT))
                && (PW'(item.pos_z) < PW'(MAX_EXTENT));
    assign wr_addr = {AW'(item.pos_x), AW'(item.pos_y), AW'(item.pos_z)};

    swtd_voxel_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (swtd_pkg::VOXEL_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.voxel_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    swtd_scan #(
        .MAX_EXTENT (MAX_EXTENT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .launch   (launch),
        .center_x (item.pos_x),
        .center_y (item.pos_y),
        .center_z (item.pos_z),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .done     (done),
        .result   (result)
    );

endmodule

// File: sv/swtd_checker.sv
// ----------------------------------------------------------------------------
// Sphere window density: port checker
// Watches the item and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "sphere_window_threshold_density_unit_macros.svh"

module swtd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input swtd_pkg::in_item_t  item,
    input logic                done,
    input swtd_pkg::out_item_t result
);

    logic acc_query;
    logic acc_write;

    assign acc_query = start && !busy && (item.operation == swtd_pkg::OP_QUERY);
    assign acc_write = start && !busy && (item.operation == swtd_pkg::OP_WRITE);

    `SWTD_ASSERT_NEXT(a_query_busy, acc_query, busy, "query item did not raise busy")
    `SWTD_ASSERT_NEXT(a_write_quiet, acc_write, !busy && !done, "write item caused busy or a result")
    `SWTD_ASSERT_SAME(a_done_after_busy, done, !busy && $past(busy), "result not at end of a query")
    `SWTD_ASSERT_NEXT(a_done_single, done, !done, "result strobe held longer than one cycle")
    `SWTD_ASSERT_SAME(a_present_nonzero, done && result.present, result.above_count != 0,
                      "present with no voxel above threshold")

endmodule

bind sphere_window_threshold_density_unit swtd_checker u_swtd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

// File: bench/tb_sphere_window_threshold_density_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere window density unit testbench
// Preloads a small home corner of the voxel store, then runs directed and
// random write/query items through the start/busy port. Every query window
// only reaches written voxels. A mirror of the store and registers counts
// each query's sphere at acceptance. The monitor compares every done strobe
// with the oldest count still due.
// ----------------------------------------------------------------------------
module tb_sphere_window_threshold_density_unit;

    localparam int RANDOM_ITEMS = 570;
    // random queries only read voxels with all coordinates below HOME
    localparam int HOME = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    swtd_pkg::in_item_t item = '0;
    logic done;
    swtd_pkg::out_item_t result;
    logic cfg_we = 1'b0;
    logic [swtd_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [swtd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    swtd_pkg::in_item_t pending_items[$];
    swtd_pkg::out_item_t sphere_counts_due[$];
    logic [swtd_pkg::VOXEL_W-1:0] voxel_mirror [0:(1 << (3 * swtd_pkg::POS_W)) - 1];
    swtd_pkg::cfg_t shadow = '{extent_x: swtd_pkg::EXTENT_RST,
                               extent_y: swtd_pkg::EXTENT_RST,
                               extent_z: swtd_pkg::EXTENT_RST,
                               window_radius: swtd_pkg::RADIUS_RST,
                               level_threshold: swtd_pkg::THRESHOLD_RST};
    int err_count = 0;
    int random_issued = 0;
    bit steady = 1'b0;

    sphere_window_threshold_density_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // inside/above counts of the sphere around a query center
    function automatic swtd_pkg::out_item_t count_sphere(input swtd_pkg::in_item_t q);
        int ex, ey, ez, r, dx, dy, dz, in_sphere, above;
        swtd_pkg::out_item_t res;
        ex = (shadow.extent_x > swtd_pkg::MAX_EXTENT_DEF) ? swtd_pkg::MAX_EXTENT_DEF
                                                           : int'(shadow.extent_x);
        ey = (shadow.extent_y > swtd_pkg::MAX_EXTENT_DEF) ? swtd_pkg::MAX_EXTENT_DEF
                                                           : int'(shadow.extent_y);
        ez = (shadow.extent_z > swtd_pkg::MAX_EXTENT_DEF) ? swtd_pkg::MAX_EXTENT_DEF
                                                           : int'(shadow.extent_z);
        r = int'(shadow.window_radius);
        if (r > swtd_pkg::MAX_RADIUS_DEF)
            r = swtd_pkg::MAX_RADIUS_DEF;
        in_sphere = 0;
        above = 0;
        for (int i = int'(q.pos_x) - r; i <= int'(q.pos_x) + r; i++)
        begin
            if (i < 0 || i >= ex)
                continue;
            for (int j = int'(q.pos_y) - r; j <= int'(q.pos_y) + r; j++)
            begin
                if (j < 0 || j >= ey)
                    continue;
                for (int k = int'(q.pos_z) - r; k <= int'(q.pos_z) + r; k++)
                begin
                    if (k < 0 || k >= ez)
                        continue;
                    dx = i - int'(q.pos_x);
                    dy = j - int'(q.pos_y);
                    dz = k - int'(q.pos_z);
                    if (dx * dx + dy * dy + dz * dz > r * r)
                        continue;
                    in_sphere++;
                    if (voxel_mirror[{i[swtd_pkg::POS_W-1:0], j[swtd_pkg::POS_W-1:0],
                                      k[swtd_pkg::POS_W-1:0]}] > shadow.level_threshold)
                        above++;
                end
            end
        end
        res.present = (swtd_pkg::PRESENT_RATIO * above > in_sphere);
        res.inside_count = in_sphere[swtd_pkg::COUNT_W-1:0];
        res.above_count = above[swtd_pkg::COUNT_W-1:0];
        return res;
    endfunction

    function automatic swtd_pkg::in_item_t make_item(input logic op, input int x, input int y,
                                                     input int z,
                                                     input logic [swtd_pkg::VOXEL_W-1:0] v);
        swtd_pkg::in_item_t it;
        it.operation = op;
        it.pos_x = x[swtd_pkg::POS_W-1:0];
        it.pos_y = y[swtd_pkg::POS_W-1:0];
        it.pos_z = z[swtd_pkg::POS_W-1:0];
        it.voxel_value = v;
        return it;
    endfunction

    function automatic void add_item(input swtd_pkg::in_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic int clip_pos(input int p);
        return (p < 0) ? 0 : ((p > 31) ? 31 : p);
    endfunction

    // center along one axis; mode 0 inside the extent, 1 anywhere, 2 a corner.
    // An axis wider than the home corner keeps the whole window below HOME.
    function automatic int pick_center(input logic [swtd_pkg::EXT_W-1:0] e, input int r,
                                       input int mode);
        int lim;
        lim = (e > swtd_pkg::MAX_EXTENT_DEF) ? swtd_pkg::MAX_EXTENT_DEF : int'(e);
        if (lim > HOME)
            return $urandom_range(HOME - 1 - r);
        case (mode)
            0: return (lim == 0) ? $urandom_range(31) : $urandom_range(lim - 1);
            1: return $urandom_range(31);
            default: return $urandom_range(1) ? 31 : 0;
        endcase
    endfunction

    function automatic logic [swtd_pkg::VOXEL_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return shadow.level_threshold + swtd_pkg::VOXEL_W'($urandom_range(2)) - 1'b1;
            default: return swtd_pkg::VOXEL_W'($urandom_range(65535));
        endcase
    endfunction

    // driver: holds an item until busy is low at an edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (item.operation == swtd_pkg::OP_WRITE)
                    voxel_mirror[{item.pos_x, item.pos_y, item.pos_z}] = item.voxel_value;
                else
                    sphere_counts_due = {sphere_counts_due, count_sphere(item)};
            end
            if (!start || !busy)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 27))
                begin
                    item <= pending_items.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (sphere_counts_due.size() == 0)
            begin
                $display("%0t: result with none due: expected none, actual %p", $time, result);
                err_count++;
            end
            else
            begin
                swtd_pkg::out_item_t want;
                want = sphere_counts_due.pop_front();
                if (result.present !== want.present)
                begin
                    $display("%0t: present mismatch: expected %0d, actual %0d",
                             $time, want.present, result.present);
                    err_count++;
                end
                if (result.inside_count !== want.inside_count)
                begin
                    $display("%0t: inside_count mismatch: expected %0d, actual %0d",
                             $time, want.inside_count, result.inside_count);
                    err_count++;
                end
                if (result.above_count !== want.above_count)
                begin
                    $display("%0t: above_count mismatch: expected %0d, actual %0d",
                             $time, want.above_count, result.above_count);
                    err_count++;
                end
            end
        end
    end

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || busy || sphere_counts_due.size() != 0);
        // a trailing write may still be in the block
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [swtd_pkg::CFG_IDX_W-1:0] a,
                             input logic [swtd_pkg::CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_cfg(input logic [swtd_pkg::EXT_W-1:0] ex,
                             input logic [swtd_pkg::EXT_W-1:0] ey,
                             input logic [swtd_pkg::EXT_W-1:0] ez,
                             input logic [swtd_pkg::RAD_W-1:0] r,
                             input logic [swtd_pkg::VOXEL_W-1:0] thr);
        wait_quiet();
        write_reg(swtd_pkg::REG_EXTENT_X, swtd_pkg::CFG_DATA_W'(ex));
        write_reg(swtd_pkg::REG_EXTENT_Y, swtd_pkg::CFG_DATA_W'(ey));
        write_reg(swtd_pkg::REG_EXTENT_Z, swtd_pkg::CFG_DATA_W'(ez));
        write_reg(swtd_pkg::REG_RADIUS, swtd_pkg::CFG_DATA_W'(r));
        write_reg(swtd_pkg::REG_THRESHOLD, thr);
        shadow.extent_x = ex;
        shadow.extent_y = ey;
        shadow.extent_z = ez;
        shadow.window_radius = r;
        shadow.level_threshold = thr;
    endtask

    initial
    begin : stimulus
        int dens [64];
        logic [swtd_pkg::EXT_W-1:0] ext [3];
        logic [swtd_pkg::RAD_W-1:0] rad;
        logic [swtd_pkg::VOXEL_W-1:0] thr;
        int n, pushed, phase, cx, cy, cz, nw, off;
        bit wide;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // fill the home corner so no query reads an unwritten voxel; density
        // varies per 2x2x2 block so present goes both ways
        foreach (dens[b])
            dens[b] = $urandom_range(10);
        steady = 1'b1;
        for (int x = 0; x < HOME; x++)
            for (int y = 0; y < HOME; y++)
                for (int z = 0; z < HOME; z++)
                    add_item(make_item(swtd_pkg::OP_WRITE, x, y, z,
                        ($urandom_range(9) < dens[(x / 2) * 16 + (y / 2) * 4 + z / 2])
                        ? swtd_pkg::VOXEL_W'($urandom_range(40000, 65535))
                        : swtd_pkg::VOXEL_W'($urandom_range(20000))));
        // last voxel on each axis and its neighbor, for the extent clamp
        add_item(make_item(swtd_pkg::OP_WRITE, 30, 0, 0, 16'd40000));
        add_item(make_item(swtd_pkg::OP_WRITE, 31, 0, 0, 16'd50000));
        add_item(make_item(swtd_pkg::OP_WRITE, 0, 30, 0, 16'd10000));
        add_item(make_item(swtd_pkg::OP_WRITE, 0, 31, 0, 16'd45000));
        add_item(make_item(swtd_pkg::OP_WRITE, 0, 0, 30, 16'd60000));
        add_item(make_item(swtd_pkg::OP_WRITE, 0, 0, 31, 16'd5000));
        wait_quiet();
        steady = 1'b0;

        // directed: corners, extreme values, thresholds, radii and extents
        add_item(make_item(swtd_pkg::OP_QUERY, 0, 0, 0, '1));
        add_item(make_item(swtd_pkg::OP_QUERY, 1, 1, 1, '0));
        add_item(make_item(swtd_pkg::OP_WRITE, 2, 2, 2, '1));
        add_item(make_item(swtd_pkg::OP_WRITE, 2, 2, 3, '0));
        add_item(make_item(swtd_pkg::OP_QUERY, 1, 0, 1, 16'h5A5A));
        apply_cfg(6'd32, 6'd32, 6'd32, 4'd0, 16'hFFFF);
        add_item(make_item(swtd_pkg::OP_QUERY, 2, 2, 2, 16'hA5A5));
        apply_cfg(6'd32, 6'd32, 6'd32, 4'd0, 16'h0000);
        add_item(make_item(swtd_pkg::OP_QUERY, 2, 2, 2, '0));
        add_item(make_item(swtd_pkg::OP_QUERY, 2, 2, 3, '0));
        apply_cfg(6'd6, 6'd6, 6'd6, 4'd15, 16'd30000);
        add_item(make_item(swtd_pkg::OP_QUERY, 2, 2, 2, '0));
        add_item(make_item(swtd_pkg::OP_QUERY, 0, 31, 0, '0));
        // zero extent: nothing in range
        apply_cfg(6'd0, 6'd0, 6'd0, 4'd4, swtd_pkg::THRESHOLD_RST);
        add_item(make_item(swtd_pkg::OP_QUERY, 5, 5, 5, '0));
        // extents beyond the store clamp to it
        apply_cfg(6'd63, 6'd1, 6'd1, 4'd1, 16'd30000);
        add_item(make_item(swtd_pkg::OP_QUERY, 31, 0, 0, '0));
        apply_cfg(6'd1, 6'd40, 6'd1, 4'd1, 16'd30000);
        add_item(make_item(swtd_pkg::OP_QUERY, 0, 31, 0, '0));
        apply_cfg(6'd1, 6'd1, 6'd33, 4'd1, 16'd30000);
        add_item(make_item(swtd_pkg::OP_QUERY, 0, 0, 31, '0));
        apply_cfg(6'd63, 6'd40, 6'd33, 4'd2, 16'd30000);
        add_item(make_item(swtd_pkg::OP_QUERY, 3, 3, 3, '0));
        add_item(make_item(swtd_pkg::OP_QUERY, 0, 1, 3, '0));
        apply_cfg(6'd1, 6'd1, 6'd1, 4'd3, 16'd25000);
        add_item(make_item(swtd_pkg::OP_QUERY, 0, 0, 0, '0));
        add_item(make_item(swtd_pkg::OP_QUERY, 10, 10, 10, '0));
        add_item(make_item(swtd_pkg::OP_QUERY, 2, 0, 0, '0));
        // center outside extent; write beyond extent is still stored
        apply_cfg(6'd5, 6'd6, 6'd4, 4'd4, 16'd35000);
        add_item(make_item(swtd_pkg::OP_QUERY, 7, 3, 2, '0));
        add_item(make_item(swtd_pkg::OP_WRITE, 31, 0, 0, '1));
        add_item(make_item(swtd_pkg::OP_QUERY, 4, 5, 3, '0));

        phase = 0;
        while (random_issued < RANDOM_ITEMS)
        begin
            wide = 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                case ($urandom_range(9))
                    0: ext[a] = 6'd0;
                    1: ext[a] = swtd_pkg::EXT_W'($urandom_range(33, 63));
                    2: ext[a] = 6'd32;
                    3: ext[a] = 6'd1;
                    default: ext[a] = swtd_pkg::EXT_W'($urandom_range(2, HOME));
                endcase
                if (ext[a] > HOME)
                    wide = 1'b1;
            end
            if (wide)
                rad = swtd_pkg::RAD_W'($urandom_range(3));
            else
                rad = ($urandom_range(9) < 7) ? swtd_pkg::RAD_W'($urandom_range(4))
                                              : swtd_pkg::RAD_W'($urandom_range(5, 7));
            case ($urandom_range(4))
                0: thr = '0;
                1: thr = '1;
                2: thr = swtd_pkg::VOXEL_W'($urandom_range(65535));
                default: thr = swtd_pkg::VOXEL_W'($urandom_range(20000, 40000));
            endcase
            apply_cfg(ext[0], ext[1], ext[2], rad, thr);
            steady = (phase == 2);
            n = $urandom_range(60, 120);
            while (n > 0)
            begin
                pushed = 0;
                case ($urandom_range(99)) inside
                    [0:54]:
                    begin
                        // a few writes around a center, then query it
                        cx = pick_center(ext[0], int'(rad), 0);
                        cy = pick_center(ext[1], int'(rad), 0);
                        cz = pick_center(ext[2], int'(rad), 0);
                        nw = $urandom_range(3);
                        for (int w = 0; w < nw; w++)
                        begin
                            off = 2 * int'(rad);
                            add_item(make_item(swtd_pkg::OP_WRITE,
                                clip_pos(cx + $urandom_range(off) - int'(rad)),
                                clip_pos(cy + $urandom_range(off) - int'(rad)),
                                clip_pos(cz + $urandom_range(off) - int'(rad)),
                                pick_value()));
                            pushed++;
                        end
                        add_item(make_item(swtd_pkg::OP_QUERY, cx, cy, cz,
                                           swtd_pkg::VOXEL_W'($urandom)));
                        pushed++;
                    end
                    [55:74]:
                    begin
                        add_item(make_item(swtd_pkg::OP_WRITE, $urandom_range(31),
                            $urandom_range(31), $urandom_range(31), pick_value()));
                        pushed++;
                    end
                    [75:89]:
                    begin
                        add_item(make_item(swtd_pkg::OP_QUERY,
                            pick_center(ext[0], int'(rad), 1),
                            pick_center(ext[1], int'(rad), 1),
                            pick_center(ext[2], int'(rad), 1),
                            swtd_pkg::VOXEL_W'($urandom)));
                        pushed++;
                    end
                    default:
                    begin
                        add_item(make_item(swtd_pkg::OP_QUERY,
                            pick_center(ext[0], int'(rad), 2),
                            pick_center(ext[1], int'(rad), 2),
                            pick_center(ext[2], int'(rad), 2),
                            swtd_pkg::VOXEL_W'($urandom)));
                        pushed++;
                    end
                endcase
                n -= pushed;
                random_issued += pushed;
            end
            phase++;
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
